@@ design/tcpid_pkg.sv @@
// ----------------------------------------------------------------------------
// tcpid_pkg
// Shared types, register codes and per-channel constant tables for the
// three-channel clamped PID block.
// ----------------------------------------------------------------------------
package tcpid_pkg;

  // Default number of controller channels held in the state memory.
  localparam int DEF_CHANNELS = 3;
  // Number of channels that have limit and bias tables.
  localparam int TAB_CH       = 3;

  // Field widths.
  localparam int CH_W     = 2;
  localparam int VAL_IN_W = 16;
  localparam int GAIN_W   = 16;
  localparam int REG_W    = 48;
  localparam int ERR_W    = 17;
  localparam int INT_W    = 17;
  localparam int DRIVE_W  = 13;
  localparam int VAL_W    = 16;

  // Configuration port geometry: 64-bit data, registers on 8-byte boundaries.
  localparam int ADDR_W      = 5;
  localparam int DATA_W      = 64;
  localparam int REG_IDX_LSB = 3;

  // Register reset values.
  localparam logic [REG_W-1:0] KP_RESET = 48'd214751641650;
  localparam logic [REG_W-1:0] KI_RESET = 48'd64425492495;
  localparam logic [REG_W-1:0] KD_RESET = 48'd107375820825;

  // Register index codes.
  typedef enum logic [1:0] {
    REG_KP = 2'd0,
    REG_KI = 2'd1,
    REG_KD = 2'd2
  } tcpid_reg_e;

  // Gain registers as seen by the datapath.
  typedef struct packed {
    logic [REG_W-1:0] kp;
    logic [REG_W-1:0] ki;
    logic [REG_W-1:0] kd;
  } tcpid_gains_t;

  // Signed working value for the output-side arithmetic.
  typedef logic signed [VAL_W-1:0] tcpid_val_t;

  // Per-channel limits and biases.
  localparam tcpid_val_t OUT_MAX [TAB_CH] = '{16'sd7811, 16'sd1812, 16'sd205};
  localparam tcpid_val_t P_MIN   [TAB_CH] = '{-16'sd7811, -16'sd575, 16'sd0};
  localparam tcpid_val_t OUT_MIN [TAB_CH] = '{-16'sd275, 16'sd0, 16'sd0};
  localparam tcpid_val_t BIAS    [TAB_CH] = '{16'sd275, 16'sd0, 16'sd22};
  localparam tcpid_val_t D_MIN            = -16'sd200;

  // Largest drive value of any channel.
  localparam logic [DRIVE_W-1:0] DRIVE_MAX = 13'd7811;

  // Integral accumulator runs in units of 1/INT_SCALE.
  localparam int INT_SCALE = 600;
  localparam int I_MAX [TAB_CH] = '{50, 100, 40};
  localparam logic [INT_W-1:0] I_LIMIT [TAB_CH] = '{
    17'(I_MAX[0] * INT_SCALE),
    17'(I_MAX[1] * INT_SCALE),
    17'(I_MAX[2] * INT_SCALE)
  };

  // Division of the proportional product by P_DIV through a reciprocal.
  // Magnitudes above PMAG_SAT land beyond every clamp limit and saturate.
  localparam int P_DIV            = 10;
  localparam int PMAG_W           = 17;
  localparam int PQ_W             = 13;
  localparam int P_RECIP_SHIFT    = 23;
  localparam int P_RECIP_W        = 20;
  localparam logic [PMAG_W-1:0] PMAG_SAT = 17'(P_DIV * (2 ** PQ_W) - 1);
  localparam logic [P_RECIP_W-1:0] P_RECIP =
    20'((2 ** P_RECIP_SHIFT + P_DIV - 1) / P_DIV);

  // Division of the accumulator by INT_SCALE through a reciprocal.
  localparam int IQ_W             = 7;
  localparam int INT_RECIP_SHIFT  = 26;
  localparam int INT_RECIP_W      = 17;
  localparam logic [INT_RECIP_W-1:0] INT_RECIP =
    17'((2 ** INT_RECIP_SHIFT + INT_SCALE - 1) / INT_SCALE);

endpackage

@@ design/tcpid_regs.sv @@
// ----------------------------------------------------------------------------
// tcpid_regs
// APB-style register file holding the proportional, integral and derivative
// gain registers, 16 bits per channel.
// ----------------------------------------------------------------------------
module tcpid_regs
  import tcpid_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]   prdata,
  output tcpid_gains_t        gains_o
);

  logic [REG_W-1:0] kp_q;
  logic [REG_W-1:0] ki_q;
  logic [REG_W-1:0] kd_q;
  logic             wr_en;
  tcpid_reg_e       reg_sel;

  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = tcpid_reg_e'(paddr[ADDR_W-1:REG_IDX_LSB]);

  // Register writes; addresses past the last register are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q <= KP_RESET;
      ki_q <= KI_RESET;
      kd_q <= KD_RESET;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_KP: kp_q <= pwdata[REG_W-1:0];
        REG_KI: ki_q <= pwdata[REG_W-1:0];
        REG_KD: kd_q <= pwdata[REG_W-1:0];
        default: ;
      endcase
    end
  end

  // Read-back mux.
  always_comb begin
    unique case (reg_sel)
      REG_KP: prdata = DATA_W'(kp_q);
      REG_KI: prdata = DATA_W'(ki_q);
      REG_KD: prdata = DATA_W'(kd_q);
      default: prdata = '0;
    endcase
  end

  assign gains_o.kp = kp_q;
  assign gains_o.ki = ki_q;
  assign gains_o.kd = kd_q;

endmodule

@@ design/three_channel_clamped_pid.sv @@
// ----------------------------------------------------------------------------
// three_channel_clamped_pid
// Three PID controllers sharing one pipelined datapath. The integral
// accumulator and previous error of each channel live in a small state memory
// that is read, updated and written back once per word.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake              Payload
//  -------  ---------  ---------------------  ---------------------------------
//  in       input      in_valid_i/in_stall_o  channel_i, target_i, measured_i
//  out      output     out_valid_o/out_stall_i drive_o
//  cfg      input      APB psel/penable/...   paddr, pwdata, prdata
//
//  One word is taken per cycle while in_stall_o is low; a drive word enters
//  stage one when its input word is taken, then moves through stages two to
//  four and into the output register.
//  The state memory is read one stage before it is written back; a word on
//  the same channel one stage behind takes the fresh state from a bypass.
//  Reset marks every memory entry as empty, so an entry reads as zero until
//  its first write; there is no clearing pass.
//  A stalled output word holds the pipeline only once the last stage is full.
//
module three_channel_clamped_pid
  import tcpid_pkg::*;
#(
  parameter int CHANNELS = DEF_CHANNELS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Sample input
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [CH_W-1:0]      channel_i,
  input  logic [VAL_IN_W-1:0]  target_i,
  input  logic [VAL_IN_W-1:0]  measured_i,
  // Drive output
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [DRIVE_W-1:0]   drive_o,
  // Configuration port
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_W-1:0]    paddr,
  input  logic [DATA_W-1:0]    pwdata,
  output logic [DATA_W-1:0]    prdata,
  output logic                 pready
);

  localparam int AW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int NVALID = (CHANNELS < TAB_CH) ? CHANNELS : TAB_CH;
  localparam int PP_W   = 2 * ERR_W;       // error times gain
  localparam int ISUM_W = PP_W + 1;        // accumulator plus product
  localparam int DIFF_W = ERR_W + 1;
  localparam int DP_W   = DIFF_W + ERR_W;  // error step times gain

  typedef struct packed {
    logic [INT_W-1:0]        isum;
    logic signed [ERR_W-1:0] last;
  } state_t;

  tcpid_gains_t gains;

  // Configuration registers.
  tcpid_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .gains_o (gains)
  );

  assign pready = 1'b1;

  // Pipeline control: all core stages move together.
  logic en_core;
  logic en_out;

  logic                      s1_v_q, s1_bad_q;
  logic [CH_W-1:0]           s1_ch_q;
  logic signed [ERR_W-1:0]   s1_err_q;

  logic                      s2_v_q, s2_bad_q;
  logic [CH_W-1:0]           s2_ch_q;
  logic signed [ERR_W-1:0]   s2_err_q;
  logic signed [PP_W-1:0]    s2_pprod_q;
  logic signed [PP_W-1:0]    s2_iprod_q;
  state_t                    rd_q;
  logic                      rd_vld_q;

  logic                      s3_v_q, s3_bad_q;
  logic [CH_W-1:0]           s3_ch_q;
  logic signed [ERR_W-1:0]   s3_err_q;
  logic [INT_W-1:0]          s3_int_q;
  logic signed [DIFF_W-1:0]  s3_diff_q;
  logic [PMAG_W-1:0]         s3_pmag_q;
  logic                      s3_pneg_q;

  logic                      s4_v_q, s4_bad_q;
  logic [CH_W-1:0]           s4_ch_q;
  logic [PQ_W-1:0]           s4_pq_q;
  logic                      s4_pneg_q;
  logic [IQ_W-1:0]           s4_iq_q;
  logic signed [DP_W-1:0]    s4_dprod_q;

  logic                      out_valid_q;
  logic [DRIVE_W-1:0]        drive_q;

  // State memory with one valid bit per entry.
  state_t                    mem [CHANNELS];
  logic [CHANNELS-1:0]       vld_q;

  assign en_out     = !out_valid_q || !out_stall_i;
  assign en_core    = !s4_v_q || en_out;
  assign in_stall_o = !en_core;

  // Input decode: channel check and error.
  logic                    in_ok;
  logic signed [ERR_W-1:0] in_err;

  assign in_ok  = (int'(channel_i) < NVALID);
  assign in_err = $signed({1'b0, target_i}) - $signed({1'b0, measured_i});

  // Stage 2 inputs: gain products and memory read address.
  logic [GAIN_W-1:0]      kp_g, ki_g, kd_g;
  logic signed [PP_W-1:0] pprod, iprod;
  logic [AW-1:0]          rd_addr;

  assign kp_g    = gains.kp[GAIN_W*s1_ch_q +: GAIN_W];
  assign ki_g    = gains.ki[GAIN_W*s1_ch_q +: GAIN_W];
  assign pprod   = s1_err_q * $signed({1'b0, kp_g});
  assign iprod   = s1_err_q * $signed({1'b0, ki_g});
  assign rd_addr = AW'(s1_ch_q);

  // Stage 3 inputs: bypass, integral update, error step, proportional size.
  logic                      fwd;
  logic [INT_W-1:0]          old_int;
  logic signed [ERR_W-1:0]   old_last;
  logic signed [ISUM_W-1:0]  isum;
  logic [INT_W-1:0]          ilim;
  logic [INT_W-1:0]          int_new;
  logic signed [DIFF_W-1:0]  diff;
  logic                      pneg;
  logic [PP_W-1:0]           pabs;
  logic [PMAG_W-1:0]         pmag;
  logic                      wr_en;
  logic [AW-1:0]             wr_addr;

  assign fwd = s3_v_q && !s3_bad_q && (s3_ch_q == s2_ch_q);

  always_comb begin
    if (fwd) begin
      old_int  = s3_int_q;
      old_last = s3_err_q;
    end else if (rd_vld_q) begin
      old_int  = rd_q.isum;
      old_last = rd_q.last;
    end else begin
      old_int  = '0;
      old_last = '0;
    end
  end

  // Accumulate and clamp to the channel's integral range.
  assign isum = $signed({{(ISUM_W-INT_W){1'b0}}, old_int}) + s2_iprod_q;
  assign ilim = I_LIMIT[s2_ch_q];

  always_comb begin
    if (isum < 0) begin
      int_new = '0;
    end else if (isum > $signed({{(ISUM_W-INT_W){1'b0}}, ilim})) begin
      int_new = ilim;
    end else begin
      int_new = isum[INT_W-1:0];
    end
  end

  assign diff = $signed({s2_err_q[ERR_W-1], s2_err_q})
              - $signed({old_last[ERR_W-1], old_last});

  // Magnitude of the proportional product, saturated past every limit.
  assign pneg = s2_pprod_q[PP_W-1];
  assign pabs = pneg ? PP_W'(-s2_pprod_q) : PP_W'(s2_pprod_q);
  assign pmag = (pabs > PP_W'(PMAG_SAT)) ? PMAG_SAT : pabs[PMAG_W-1:0];

  assign wr_en   = en_core && s2_v_q && !s2_bad_q;
  assign wr_addr = AW'(s2_ch_q);

  // Stage 4 inputs: reciprocal divisions and derivative product.
  logic [PMAG_W+P_RECIP_W-1:0]  pq_full;
  logic [INT_W+INT_RECIP_W-1:0] iq_full;
  logic signed [DP_W-1:0]       dprod;

  assign kd_g    = gains.kd[GAIN_W*s3_ch_q +: GAIN_W];
  assign pq_full = s3_pmag_q * P_RECIP;
  assign iq_full = s3_int_q * INT_RECIP;
  assign dprod   = s3_diff_q * $signed({1'b0, kd_g});

  // Output stage: clamp the P and D terms, add the I term, clamp, add bias, clamp.
  tcpid_val_t hi, p_val, p_cl, d_cl, sum, sum_cl, biased, res;
  logic [DRIVE_W-1:0] drive_d;

  assign hi    = OUT_MAX[s4_ch_q];
  assign p_val = s4_pneg_q ? -$signed({{(VAL_W-PQ_W){1'b0}}, s4_pq_q})
                           :  $signed({{(VAL_W-PQ_W){1'b0}}, s4_pq_q});

  always_comb begin
    p_cl = p_val;
    if (p_cl < P_MIN[s4_ch_q]) begin
      p_cl = P_MIN[s4_ch_q];
    end
    if (p_cl > hi) begin
      p_cl = hi;
    end
  end

  always_comb begin
    if (s4_dprod_q > DP_W'(hi)) begin
      d_cl = hi;
    end else if (s4_dprod_q < DP_W'(D_MIN)) begin
      d_cl = D_MIN;
    end else begin
      d_cl = s4_dprod_q[VAL_W-1:0];
    end
  end

  assign sum = p_cl + $signed({{(VAL_W-IQ_W){1'b0}}, s4_iq_q}) + d_cl;

  always_comb begin
    sum_cl = sum;
    if (sum_cl < OUT_MIN[s4_ch_q]) begin
      sum_cl = OUT_MIN[s4_ch_q];
    end
    if (sum_cl > hi) begin
      sum_cl = hi;
    end
  end

  assign biased  = sum_cl + BIAS[s4_ch_q];
  assign res     = (biased < hi) ? biased : hi;
  assign drive_d = s4_bad_q ? '0 : res[DRIVE_W-1:0];

  // Valid bits of the pipeline and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q      <= 1'b0;
      s2_v_q      <= 1'b0;
      s3_v_q      <= 1'b0;
      s4_v_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (en_core) begin
        s1_v_q <= in_valid_i;
        s2_v_q <= s1_v_q;
        s3_v_q <= s2_v_q;
        s4_v_q <= s3_v_q;
      end
      if (en_out) begin
        out_valid_q <= s4_v_q;
      end
    end
  end

  // Pipeline payload.
  always_ff @(posedge clk_i) begin
    if (en_core) begin
      s1_bad_q   <= !in_ok;
      s1_ch_q    <= in_ok ? channel_i : '0;
      s1_err_q   <= in_err;

      s2_bad_q   <= s1_bad_q;
      s2_ch_q    <= s1_ch_q;
      s2_err_q   <= s1_err_q;
      s2_pprod_q <= pprod;
      s2_iprod_q <= iprod;

      s3_bad_q   <= s2_bad_q;
      s3_ch_q    <= s2_ch_q;
      s3_err_q   <= s2_err_q;
      s3_int_q   <= int_new;
      s3_diff_q  <= diff;
      s3_pmag_q  <= pmag;
      s3_pneg_q  <= pneg;

      s4_bad_q   <= s3_bad_q;
      s4_ch_q    <= s3_ch_q;
      s4_pq_q    <= pq_full[P_RECIP_SHIFT +: PQ_W];
      s4_pneg_q  <= s3_pneg_q;
      s4_iq_q    <= iq_full[INT_RECIP_SHIFT +: IQ_W];
      s4_dprod_q <= dprod;
    end
    if (en_out) begin
      drive_q <= drive_d;
    end
  end

  // State memory: read in stage 1, written back from stage 2.
  always_ff @(posedge clk_i) begin
    if (en_core) begin
      rd_q <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= '{isum: int_new, last: s2_err_q};
    end
  end

  // Entry valid bits; an empty entry reads as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (en_core) begin
        rd_vld_q <= vld_q[rd_addr];
      end
      if (wr_en) begin
        vld_q[wr_addr] <= 1'b1;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign drive_o     = drive_q;

`ifndef NO_ASSERTIONS
  // A drive word only appears when the last stage held a word.
  a_out_from_s4: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s4_v_q))
    else $error("drive word appeared without a word in the last stage");

  // A sample for an unknown channel answers zero.
  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_core && s4_v_q && s4_bad_q) |=> (drive_q == '0))
    else $error("unknown channel did not answer zero");

  // The stored accumulator never leaves the channel's integral range.
  a_int_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (int_new <= I_LIMIT[s2_ch_q]))
    else $error("integral write beyond its limit");

  // Delivered drive stays within the largest channel range.
  a_drive_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (drive_q <= DRIVE_MAX))
    else $error("drive above maximum");
`endif

endmodule
